>>> design/tbss_pkg.sv
`timescale 1ns / 1ps

package tbss_pkg;

    localparam int MASK_BITS = 64;
    localparam logic [63:0] MASK_KEEP = ~64'd0 >> (64 - MASK_BITS);

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int FAIL_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 168;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 144;

    localparam logic [TIME_W-1:0] KEEP_MIN_MS = 32'd1000;
    localparam logic [TIME_W-1:0] KEEP_MAX_MS = 32'd4000;
    localparam logic [FAIL_W-1:0] FAIL_LIMIT  = 8'd3;
    localparam logic [FAIL_W-1:0] FAIL_SAT    = 8'd255;
    localparam logic [TIME_W-1:0] TALLY_TIME_RESET = 32'd0 - 32'd10000;
    localparam logic [CFG_W-1:0]  BURST_LEN_RESET  = 16'd500;
    localparam logic [CFG_W-1:0]  BURST_GAP_RESET  = 16'd50;

    localparam logic PKT_TALLY = 1'b0;
    localparam logic PKT_SLEEP = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_STATUS = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLEEP     = 2'd0,
        CFG_BURST_LEN = 2'd1,
        CFG_BURST_GAP = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic              kind;
        logic [63:0]       prog;
        logic [63:0]       preview;
        logic [CFG_W-1:0]  sleep_len;
        logic              last;
    } t_pkt;

    // wrapping time compare: a is earlier than b
    function automatic logic is_before(input logic [TIME_W-1:0] a,
                                       input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

endpackage

>>> design/tally_burst_sleep_scheduler_top.sv
`timescale 1ns / 1ps

// Tally burst / sleep scheduler.
// Input stream: one beat per item (loop tick, tally update, send status), each with its
// millisecond timestamp. Output stream: tally packets (tuser 0) carrying the program and
// preview masks, and sleep packets (tuser 1) carrying the sleep time; tlast marks the
// final packet caused by an item. An item can cause zero, one or two packets.
// Configuration: i_cfg_we with i_cfg_idx selects sleep length (0), burst length (1) or
// burst gap (2); write only while the block is idle.
// An accepted beat is evaluated while it sits in the input register, and its first packet
// is loaded into the result register when the evaluation stage fires.
// Throughput: one item per cycle while items cause at most one packet and the receiver
// takes each beat; a two-packet item holds the two-entry result register for two beats.
// The evaluation stage fires only when the result register is empty or its last beat
// leaves in the same cycle.
// Reset (synchronous, active low) clears scheduler state (last tally time to -10000 ms),
// sets the burst length to 500 ms, the gap to 50 ms, sleep to 0 and empties both registers.
// When the receiver stalls, the result register holds its beat, the evaluation stage
// waits and o_s_axis_tready drops once the input register is full.

module tally_burst_sleep_scheduler_top import tbss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // now_ms[31:0], program_mask[95:32], preview_mask[159:96], send_ok[160], zero pad
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // op[1:0], set_program[2], set_preview[3]
    input  logic [S_TUSER_W-1:0]  i_s_axis_tuser,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // out_program[63:0], out_preview[127:64], out_sleep_ms[143:128]
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    // packet_kind
    output logic                  o_m_axis_tuser,
    output logic                  o_m_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    // configuration
    logic [CFG_W-1:0] r_sleep, r_len, r_gap;

    // input register
    logic              r_in_v;
    logic [1:0]        r_op;
    logic [TIME_W-1:0] r_now;
    logic [63:0]       r_prog_in, r_prev_in;
    logic              r_set_prog, r_set_prev, r_send_ok;

    // scheduler state
    logic [63:0]       r_cur_program, r_cur_preview, r_snap_program, r_snap_preview;
    logic              r_burst_on, r_pending, r_was_bursting;
    logic [TIME_W-1:0] r_burst_end, r_next_send, r_wake_time, r_last_tally;
    logic [FAIL_W-1:0] r_fail_run;

    logic [63:0]       n_cur_program, n_cur_preview, n_snap_program, n_snap_preview;
    logic              n_burst_on, n_pending, n_was_bursting;
    logic [TIME_W-1:0] n_burst_end, n_next_send, n_wake_time, n_last_tally;
    logic [FAIL_W-1:0] n_fail_run;

    // result register
    t_pkt       r_pk0, r_pk1, n_pk0, n_pk1;
    logic [1:0] r_cnt, n_cnt;

    logic s_hs, m_hs, fire;
    logic burst_dead, active, bt_send, sleep_emit, tick_go, fail_hit, keep_hit, upd_ok;
    logic [TIME_W-1:0] ns1, ns2, win, win_raw;
    logic [CFG_W:0]    win_sum;
    logic [63:0]       upd_program, upd_preview;
    t_pkt              cur_pk, snap_pk, sleep_pk;

    assign s_hs = i_s_axis_tvalid && o_s_axis_tready;
    assign m_hs = o_m_axis_tvalid && i_m_axis_tready;
    assign fire = r_in_v && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_hs));
    assign o_s_axis_tready = !r_in_v || fire;

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {r_pk0.sleep_len, r_pk0.preview, r_pk0.prog};
    assign o_m_axis_tuser  = r_pk0.kind;
    assign o_m_axis_tlast  = r_pk0.last;

    // burst timing
    assign burst_dead = !is_before(r_now, r_burst_end);
    assign active     = r_burst_on && !burst_dead;
    assign bt_send    = active && !is_before(r_now, r_next_send);
    assign ns1        = r_next_send + {16'd0, r_gap};
    assign ns2        = is_before(ns1, r_now) ? r_now : ns1;
    assign sleep_emit = r_was_bursting && !active && (r_sleep != '0);
    // a fresh sleep always pushes the wake time past now
    assign tick_go    = !active && !sleep_emit && !is_before(r_now, r_wake_time);
    assign fail_hit   = (r_fail_run >= FAIL_LIMIT);
    assign upd_ok     = !is_before(r_now, r_wake_time);

    // keepalive window clamp
    assign win_sum  = {1'b0, r_sleep} + {1'b0, r_len};
    assign win_raw  = {15'd0, win_sum};
    assign win      = (win_raw > KEEP_MAX_MS) ? KEEP_MAX_MS :
                      (win_raw < KEEP_MIN_MS) ? KEEP_MIN_MS : win_raw;
    assign keep_hit = ((r_now - r_last_tally) > win);

    assign upd_program = r_set_prog ? (r_prog_in & MASK_KEEP) : r_cur_program;
    assign upd_preview = r_set_prev ? (r_prev_in & MASK_KEEP) : r_cur_preview;

    assign cur_pk   = '{kind: PKT_TALLY, prog: r_cur_program, preview: r_cur_preview,
                        sleep_len: '0, last: 1'b0};
    assign snap_pk  = '{kind: PKT_TALLY, prog: r_snap_program, preview: r_snap_preview,
                        sleep_len: '0, last: 1'b0};
    assign sleep_pk = '{kind: PKT_SLEEP, prog: '0, preview: '0,
                        sleep_len: r_sleep, last: 1'b0};

    always_comb begin
        n_cur_program  = r_cur_program;
        n_cur_preview  = r_cur_preview;
        n_snap_program = r_snap_program;
        n_snap_preview = r_snap_preview;
        n_burst_on     = r_burst_on;
        n_pending      = r_pending;
        n_was_bursting = r_was_bursting;
        n_burst_end    = r_burst_end;
        n_next_send    = r_next_send;
        n_wake_time    = r_wake_time;
        n_last_tally   = r_last_tally;
        n_fail_run     = r_fail_run;
        n_pk0          = cur_pk;
        n_pk1          = cur_pk;
        n_cnt          = 2'd0;
        case (t_op'(r_op))
            OP_TICK: begin
                if (r_burst_on && burst_dead) begin
                    n_burst_on = 1'b0;
                end
                if (bt_send) begin
                    n_next_send = ns2;
                    n_pk0       = snap_pk;
                    n_cnt       = 2'd1;
                end
                if (sleep_emit) begin
                    n_pk0       = sleep_pk;
                    n_cnt       = 2'd1;
                    n_wake_time = r_now + {16'd0, r_sleep};
                end
                n_was_bursting = active;
                if (tick_go) begin
                    if (fail_hit) begin
                        n_fail_run = '0;
                    end
                    // pending flush, forced resync or keepalive all start a burst
                    if (r_pending || fail_hit || keep_hit) begin
                        n_pending      = 1'b0;
                        n_last_tally   = r_now;
                        n_snap_program = r_cur_program;
                        n_snap_preview = r_cur_preview;
                        n_burst_on     = 1'b1;
                        n_burst_end    = r_now + {16'd0, r_len};
                        n_next_send    = r_now + {16'd0, r_gap};
                        n_pk0          = cur_pk;
                        n_cnt          = (r_pending && fail_hit) ? 2'd2 : 2'd1;
                    end
                end
            end
            OP_UPDATE: begin
                n_cur_program = upd_program;
                n_cur_preview = upd_preview;
                if (upd_ok) begin
                    n_pending      = 1'b0;
                    n_last_tally   = r_now;
                    n_snap_program = upd_program;
                    n_snap_preview = upd_preview;
                    n_burst_on     = 1'b1;
                    n_burst_end    = r_now + {16'd0, r_len};
                    n_next_send    = r_now + {16'd0, r_gap};
                    n_pk0          = '{kind: PKT_TALLY, prog: upd_program,
                                       preview: upd_preview, sleep_len: '0, last: 1'b0};
                    n_cnt          = 2'd1;
                end else begin
                    n_pending = 1'b1;
                end
            end
            OP_STATUS: begin
                if (r_send_ok) begin
                    n_fail_run = '0;
                end else if (r_fail_run < FAIL_SAT) begin
                    n_fail_run = r_fail_run + 8'd1;
                end
            end
            default: begin
            end
        endcase
        n_pk0.last = (n_cnt == 2'd1);
        n_pk1.last = 1'b1;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep <= '0;
            r_len   <= BURST_LEN_RESET;
            r_gap   <= BURST_GAP_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SLEEP:     r_sleep <= i_cfg_wdata;
                CFG_BURST_LEN: r_len   <= i_cfg_wdata;
                CFG_BURST_GAP: r_gap   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (s_hs) begin
            r_in_v <= 1'b1;
        end else if (fire) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_hs) begin
            r_now      <= i_s_axis_tdata[31:0];
            r_prog_in  <= i_s_axis_tdata[95:32];
            r_prev_in  <= i_s_axis_tdata[159:96];
            r_send_ok  <= i_s_axis_tdata[160];
            r_op       <= i_s_axis_tuser[1:0];
            r_set_prog <= i_s_axis_tuser[2];
            r_set_prev <= i_s_axis_tuser[3];
        end
    end

    // scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_program  <= '0;
            r_cur_preview  <= '0;
            r_snap_program <= '0;
            r_snap_preview <= '0;
            r_burst_on     <= 1'b0;
            r_pending      <= 1'b0;
            r_was_bursting <= 1'b0;
            r_burst_end    <= '0;
            r_next_send    <= '0;
            r_wake_time    <= '0;
            r_last_tally   <= TALLY_TIME_RESET;
            r_fail_run     <= '0;
        end else if (fire) begin
            r_cur_program  <= n_cur_program;
            r_cur_preview  <= n_cur_preview;
            r_snap_program <= n_snap_program;
            r_snap_preview <= n_snap_preview;
            r_burst_on     <= n_burst_on;
            r_pending      <= n_pending;
            r_was_bursting <= n_was_bursting;
            r_burst_end    <= n_burst_end;
            r_next_send    <= n_next_send;
            r_wake_time    <= n_wake_time;
            r_last_tally   <= n_last_tally;
            r_fail_run     <= n_fail_run;
        end
    end

    // result register, up to two beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (fire) begin
            r_cnt <= n_cnt;
        end else if (m_hs) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pk0 <= n_pk0;
            r_pk1 <= n_pk1;
        end else if (m_hs) begin
            r_pk0 <= r_pk1;
        end
    end

endmodule

>>> design/tbss_checker.sv
`timescale 1ns / 1ps

module tbss_checker import tbss_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                 o_m_axis_tuser,
    input logic                 o_m_axis_tlast,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready
);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output beat valid right after reset");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled output beat changed");

    // sleep packet: no masks, nonzero sleep time, always the final packet
    a_sleep_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == PKT_SLEEP) |->
            (o_m_axis_tdata[127:0] == '0) && (o_m_axis_tdata[143:128] != '0)
            && o_m_axis_tlast)
        else $error("malformed sleep packet");

    // tally packet carries no sleep time
    a_tally_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == PKT_TALLY) |->
            (o_m_axis_tdata[143:128] == '0))
        else $error("tally packet with sleep time");

    // a beat without tlast is followed straight by the second tally packet of its item
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid && o_m_axis_tlast && (o_m_axis_tuser == PKT_TALLY)
            && (o_m_axis_tdata == $past(o_m_axis_tdata)))
        else $error("second packet of a pair missing or different");

endmodule

bind tally_burst_sleep_scheduler_top tbss_checker u_tbss_checker (.*);
